### rtl/abg_pkg.sv
// shared types and constants for the adc average battery gauge
package abg_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int VOLT_W     = 9;
   localparam int PCT_W      = 7;
   localparam int INTERVAL_W = 16;
   localparam int FULL_W     = 8;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic REG_INTERVAL = 1'b0;
   localparam logic REG_FULL     = 1'b1;

   // word kinds on the request tuser
   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
   localparam logic [FULL_W-1:0]     FULL_RESET     = 8'd168;
   localparam logic [INTERVAL_W-1:0] ELAPSED_MAX    = 16'hFFFF;
   localparam logic [VOLT_W-1:0]     HIGH_TENTHS    = 9'd150;
   localparam logic [PCT_W-1:0]      FULL_PCT       = 7'd100;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### rtl/adc_average_battery_gauge.sv
// adc average battery gauge: sample accumulator, sequencer and result register
//
// req channel: tuser is the word kind (0 = one millisecond tick, 1 = adc sample),
// tdata carries the 12-bit sample. a tick or a sample that does not trigger an
// update leaves req_tready high. a sample that triggers an update (first sample
// after reset, or elapsed time at the update interval) runs one shared restoring
// divider of 12+COUNT_BITS bits, one bit per cycle: the average, then the
// percentage unless the voltage is 150 tenths or more or the full scale is zero.
// req_tready stays low during an update and returns high in the same cycle as
// the new result is registered for the rsp channel.
// rsp channel: tdata holds voltage in tenths and percentage. the result sits in
// an output register; new words are taken while it waits, and a finished
// update holds in its last step until the register is free.
// csr port: index 0 is the update interval in ms, index 1 the full scale in
// tenths of a volt. write only while idle.
// reset is synchronous: sums, count and timer clear, registers take their
// defaults, and the next sample always gives an update.
module adc_average_battery_gauge
   import abg_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // adc_sample[11:0], zero pad
   input  logic                  req_tuser,   // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // voltage_tenths[8:0], percentage[15:9]
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W = SAMPLE_W + COUNT_BITS;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_AVG_START = 3'd1;
   localparam logic [2:0] ST_AVG_WAIT  = 3'd2;
   localparam logic [2:0] ST_PCT       = 3'd3;
   localparam logic [2:0] ST_PCT_WAIT  = 3'd4;
   localparam logic [2:0] ST_EMIT      = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [INTERVAL_W-1:0] elapsed_ff, elapsed_in;
   logic                  first_ff, first_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [FULL_W-1:0]     full_ff, full_in;
   logic [VOLT_W-1:0]     volts_ff, volts_in;
   logic [PCT_W-1:0]      pct_ff, pct_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_data_ff, rsp_data_in;

   logic                  div_start;
   logic [SUM_W-1:0]      div_dividend, div_divisor, div_quot;
   div_stat_type          div_stat;
   logic                  req_fire;
   logic [17:0]           avg_x33;
   logic [15:0]           volts_x100;

   abg_divider #(
      .DIV_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .status   (div_stat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;

   // avg*2640/40960 is avg*33/512
   assign avg_x33    = {1'b0, div_quot[SAMPLE_W-1:0], 5'b0} + 18'(div_quot[SAMPLE_W-1:0]);
   assign volts_x100 = {1'b0, volts_ff, 6'b0} + {2'b0, volts_ff, 5'b0}
                     + {5'b0, volts_ff, 2'b0};

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      elapsed_in   = elapsed_ff;
      first_in     = first_ff;
      volts_in     = volts_ff;
      pct_in       = pct_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      div_start    = 1'b0;
      div_dividend = sum_ff;
      div_divisor  = SUM_W'(count_ff);
      interval_in  = interval_ff;
      full_in      = full_ff;

      if (csr_we) begin
         case (csr_index)
            REG_INTERVAL: interval_in = csr_wdata[INTERVAL_W-1:0];
            REG_FULL:     full_in = csr_wdata[FULL_W-1:0];
            default:      interval_in = interval_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == MODE_TICK) begin
                  if (elapsed_ff != ELAPSED_MAX) begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
               end else begin
                  if (count_ff != {COUNT_BITS{1'b1}}) begin
                     sum_in   = sum_ff + SUM_W'(req_tdata[SAMPLE_W-1:0]);
                     count_in = count_ff + 1'b1;
                  end
                  if (first_ff || elapsed_ff >= interval_ff) begin
                     state_in = ST_AVG_START;
                  end
               end
            end
         end
         ST_AVG_START: begin
            div_start = 1'b1;
            state_in  = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_stat.done) begin
               volts_in = avg_x33[17:9];
               state_in = ST_PCT;
            end
         end
         ST_PCT: begin
            if (volts_ff >= HIGH_TENTHS || full_ff == '0) begin
               pct_in   = FULL_PCT;
               state_in = ST_EMIT;
            end else begin
               div_start    = 1'b1;
               div_dividend = SUM_W'(volts_x100);
               div_divisor  = SUM_W'(full_ff);
               state_in     = ST_PCT_WAIT;
            end
         end
         ST_PCT_WAIT: begin
            if (div_stat.done) begin
               pct_in   = (div_quot > SUM_W'(FULL_PCT)) ? FULL_PCT : div_quot[PCT_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pct_ff, volts_ff};
               sum_in       = '0;
               count_in     = '0;
               elapsed_in   = '0;
               first_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      volts_ff    <= volts_in;
      pct_ff      <= pct_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         elapsed_ff   <= '0;
         first_ff     <= 1'b1;
         interval_ff  <= INTERVAL_RESET;
         full_ff      <= FULL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         elapsed_ff   <= elapsed_in;
         first_ff     <= first_in;
         interval_ff  <= interval_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/abg_divider.sv
// shared restoring divider, one quotient bit per cycle
module abg_divider
   import abg_pkg::*;
#(
   parameter int DIV_W = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output div_stat_type     status
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W+1:0] diff;
   logic             neg;

   assign trial = {rem_ff, quot_ff[DIV_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};
   assign neg   = diff[DIV_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quot_in = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = neg ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
         quot_in = {quot_ff[DIV_W-2:0], ~neg};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### tb/tb_adc_average_battery_gauge.sv
// self-checking testbench for the adc average battery gauge with a reading scoreboard
module tb_adc_average_battery_gauge
   import abg_pkg::*;
;
   localparam int COUNT_BITS  = 16;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = 80;
   localparam int RAND_WORDS  = 360;

   typedef struct packed {
      logic [PCT_W-1:0]  percentage;
      logic [VOLT_W-1:0] voltage_tenths;
   } gauge_reading_type;

   class gauge_scoreboard;
      logic [INTERVAL_W-1:0]      interval_ms;
      logic [FULL_W-1:0]          full_tenths;
      logic [12+COUNT_BITS-1:0]   sum;
      logic [COUNT_BITS-1:0]      count;
      logic [INTERVAL_W-1:0]      elapsed;
      bit                         first;
      gauge_reading_type          readings[$];
      int                         errors;
      int                         checked;
      int                         updates;

      function new();
         interval_ms = INTERVAL_RESET;
         full_tenths = FULL_RESET;
         sum         = '0;
         count       = '0;
         elapsed     = '0;
         first       = 1'b1;
         errors      = 0;
         checked     = 0;
         updates     = 0;
      endfunction

      function void set_reg(logic index, logic [CSR_DATA_W-1:0] value);
         if (index == REG_INTERVAL)
            interval_ms = value[INTERVAL_W-1:0];
         else
            full_tenths = value[FULL_W-1:0];
      endfunction

      // one accepted request word
      function void note_word(logic mode, logic [SAMPLE_W-1:0] sample);
         int unsigned       avg;
         int unsigned       volts;
         int unsigned       pct;
         gauge_reading_type r;
         if (mode == MODE_TICK) begin
            if (elapsed != ELAPSED_MAX)
               elapsed = elapsed + 1'b1;
            return;
         end
         if (count != {COUNT_BITS{1'b1}}) begin
            sum   = sum + sample;
            count = count + 1'b1;
         end
         if (!first && elapsed < interval_ms)
            return;
         avg   = (count == 0) ? 0 : int'(sum) / int'(count);
         volts = (avg * 2640) / 40960;
         if (volts >= HIGH_TENTHS || full_tenths == 0) begin
            pct = FULL_PCT;
         end else begin
            pct = (volts * 100) / full_tenths;
            if (pct > FULL_PCT)
               pct = FULL_PCT;
         end
         r.voltage_tenths = volts[VOLT_W-1:0];
         r.percentage     = pct[PCT_W-1:0];
         readings.push_back(r);
         updates++;
         sum     = '0;
         count   = '0;
         elapsed = '0;
         first   = 1'b0;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10)
            $display("error: %s", msg);
      endfunction

      function void check_reading(logic [15:0] word);
         gauge_reading_type got;
         gauge_reading_type exp_r;
         got = word;
         checked++;
         if (readings.size() == 0) begin
            report($sformatf("unexpected reading volt=%0d pct=%0d",
                             got.voltage_tenths, got.percentage));
            return;
         end
         exp_r = readings.pop_front();
         if (got.voltage_tenths !== exp_r.voltage_tenths)
            report($sformatf("reading %0d voltage expected %0d got %0d", checked,
                             exp_r.voltage_tenths, got.voltage_tenths));
         if (got.percentage !== exp_r.percentage)
            report($sformatf("reading %0d percentage expected %0d got %0d", checked,
                             exp_r.percentage, got.percentage));
      endfunction

      function int pending();
         return readings.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;   // adc_sample[11:0], zero pad
   logic                  req_tuser  = MODE_TICK;   // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;   // voltage_tenths[8:0], percentage[15:9]
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = REG_INTERVAL;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   gauge_scoreboard sb = new();

   bit send_idle   = 1'b1;
   bit recv_idle   = 1'b1;
   int hold_cycles = 0;
   int stall_count = 0;
   int words_sent  = 0;
   int rand_words  = 0;

   adc_average_battery_gauge #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // reading sink with random back pressure and a long hold on request
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         sb.check_reading(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(recv_idle && $urandom_range(0, 99) < 31);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic offer_word(input logic mode, input logic [SAMPLE_W-1:0] sample);
      while (send_idle && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0, sample};
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_word(mode, sample);
      words_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_config(input logic [INTERVAL_W-1:0] interval,
                               input logic [FULL_W-1:0] full);
      logic [CSR_DATA_W-1:0] full_word;
      full_word = {8'($urandom), full};
      csr_we    <= 1'b1;
      csr_index <= REG_INTERVAL;
      csr_wdata <= interval;
      @(posedge clock);
      csr_index <= REG_FULL;
      csr_wdata <= full_word;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(REG_INTERVAL, interval);
      sb.set_reg(REG_FULL, full_word);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   initial begin
      int n;
      int tick_pct;
      int phase;
      logic [INTERVAL_W-1:0] interval;
      logic [FULL_W-1:0] full;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first sample after reset, then a sample short of the interval
      offer_word(MODE_SAMPLE, 12'hFFF);
      offer_word(MODE_TICK, 12'h000);
      offer_word(MODE_SAMPLE, 12'h000);
      settle();

      // zero interval with zero full scale
      write_config(16'd0, 8'd0);
      offer_word(MODE_SAMPLE, 12'd1234);
      offer_word(MODE_SAMPLE, 12'd0);
      settle();

      // full scale below the high voltage point
      write_config(16'd0, 8'd100);
      offer_word(MODE_SAMPLE, 12'd2400);
      offer_word(MODE_SAMPLE, 12'd2000);
      offer_word(MODE_SAMPLE, 12'd1000);
      settle();

      // around the high voltage point at full scales of 255 and 150
      write_config(16'd1, 8'd255);
      offer_word(MODE_SAMPLE, 12'd2327);
      offer_word(MODE_TICK, 12'hFFF);
      offer_word(MODE_SAMPLE, 12'd2327);
      offer_word(MODE_SAMPLE, 12'd2328);
      offer_word(MODE_TICK, 12'd0);
      offer_word(MODE_TICK, 12'd0);
      offer_word(MODE_SAMPLE, 12'd2328);
      settle();
      write_config(16'd1, 8'd150);
      offer_word(MODE_SAMPLE, 12'd2327);
      offer_word(MODE_TICK, 12'd0);
      offer_word(MODE_SAMPLE, 12'd2327);
      offer_word(MODE_SAMPLE, 12'h555);
      offer_word(MODE_TICK, 12'd0);
      offer_word(MODE_SAMPLE, 12'hAAA);
      settle();

      // sink holds off while every sample asks for an update
      write_config(16'd0, 8'($urandom_range(150, 255)));
      hold_cycles = 600;
      for (int i = 0; i < 20; i++)
         offer_word(MODE_SAMPLE, pick_sample());
      settle();

      phase = 0;
      while (rand_words < RAND_WORDS) begin
         case ($urandom_range(0, 9))
            0:       interval = 16'd0;
            1:       interval = 16'hFFFF;
            2:       interval = 16'($urandom_range(13, 40));
            default: interval = 16'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 9))
            0:       full = 8'd150;
            1:       full = 8'd255;
            2:       full = 8'($urandom_range(0, 149));
            default: full = 8'($urandom_range(150, 255));
         endcase
         write_config(interval, full);
         send_idle = (phase != 2);
         recv_idle = (phase != 2);
         tick_pct  = $urandom_range(30, 85);
         n         = $urandom_range(30, 60);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < tick_pct)
               offer_word(MODE_TICK, SAMPLE_W'($urandom));
            else
               offer_word(MODE_SAMPLE, pick_sample());
            rand_words++;
         end
         settle();
         phase++;
      end

      $display("covered %0d request words and %0d readings (%0d updates), %0d random words in %0d phases",
               words_sent, sb.checked, sb.updates, rand_words, phase);
      $display("with zero interval, full scale extremes and a long sink hold-off");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

### files.f
rtl/abg_pkg.sv
rtl/abg_divider.sv
rtl/adc_average_battery_gauge.sv
tb/tb_adc_average_battery_gauge.sv
